@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds in the same cycle
`define DSSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check that holds in the next cycle
`define DSSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/dssc_pkg.sv @@
// shared types, constants and segment decoder of the seven-segment writer
`timescale 1ns / 1ps
package dssc_pkg;

	localparam int VALUE_W = 27;
	localparam int MAP_W   = 21;
	localparam int CNT_W   = 4;
	localparam int CHAN_W  = 6;
	localparam int LEVEL_W = 12;
	localparam int NUM_SEGS = 7;
	localparam int PROD_W  = VALUE_W + 32;

	localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
	localparam int RECIP_SHIFT = 35;

	localparam logic [2:0] SEG_LAST = 3'(NUM_SEGS - 1);

	localparam logic [1:0] CFG_SEGMENT_MAP  = 2'd0;
	localparam logic [1:0] CFG_COMMON_ANODE = 2'd1;
	localparam logic [1:0] CFG_DIGIT_COUNT  = 2'd2;

	typedef struct packed {
		logic [MAP_W-1:0] segment_map;
		logic             common_anode;
		logic [CNT_W-1:0] n;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic take;
	} seq_stat_t;

	function automatic logic [NUM_SEGS-1:0] seg_pattern(input logic [3:0] d);
		logic [NUM_SEGS-1:0] p;
		unique case (d)
			4'd0: p = 7'h3F;
			4'd1: p = 7'h06;
			4'd2: p = 7'h5B;
			4'd3: p = 7'h4F;
			4'd4: p = 7'h66;
			4'd5: p = 7'h6D;
			4'd6: p = 7'h7D;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7F;
			4'd9: p = 7'h6F;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

endpackage

@@ hw/rtl/decimal_seven_segment_channel_writer.sv @@
// top level of the decimal seven-segment channel writer
`timescale 1ns / 1ps
// Splits an unsigned value into decimal digits and writes one driver channel per
// segment A..G of every digit position, MAX_DIGITS cells in a row each taking off one
// digit per cycle while the row advances. A word needs 7 * min(digit_count,
// MAX_DIGITS) writes on the output port, which takes one write per cycle while
// out_ready is high; a new word is accepted in every cycle in which the last cell is
// empty or hands its word to the sequencer, so the output port sets the sustained rate.
// With digit_count zero a word produces no writes. Configuration is written through
// cfg_we, cfg_index and cfg_wdata.
module decimal_seven_segment_channel_writer #(
	parameter int MAX_DIGITS = 8,
	parameter int CHANNELS_PER_DIGIT = 8,
	parameter int FULL_LEVEL = 4095
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [dssc_pkg::MAP_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dssc_pkg::VALUE_W-1:0]  value,
	input  logic                          blank,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dssc_pkg::CHAN_W-1:0]   channel,
	output logic [dssc_pkg::LEVEL_W-1:0]  level,
	output logic                          latch,
	output logic                          last
);
	import dssc_pkg::*;
	`include "assert_macros.svh"

	logic [MAP_W-1:0] segment_map_q;
	logic             common_anode_q;
	logic [CNT_W-1:0] digit_count_q;
	cfg_t             cfg;
	seq_stat_t        stat;
	logic             adv;

	logic                    v_c      [0:MAX_DIGITS];
	logic [VALUE_W-1:0]      num_c    [0:MAX_DIGITS];
	logic                    blank_c  [0:MAX_DIGITS];
	logic [4*MAX_DIGITS-1:0] digits_c [0:MAX_DIGITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_map_q  <= MAP_W'(1754760);
			common_anode_q <= 1'b1;
			digit_count_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SEGMENT_MAP:  segment_map_q  <= cfg_wdata;
				CFG_COMMON_ANODE: common_anode_q <= cfg_wdata[0];
				CFG_DIGIT_COUNT:  digit_count_q  <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.segment_map  = segment_map_q;
		cfg.common_anode = common_anode_q;
		cfg.n = (digit_count_q > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : digit_count_q;
	end

	assign adv      = !v_c[MAX_DIGITS] || stat.take;
	assign in_ready = adv;

	assign v_c[0]      = in_valid;
	assign num_c[0]    = value;
	assign blank_c[0]  = blank;
	assign digits_c[0] = '0;

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		dssc_cell #(
			.MAX_DIGITS(MAX_DIGITS),
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_v      (v_c[i]),
			.in_num    (num_c[i]),
			.in_blank  (blank_c[i]),
			.in_digits (digits_c[i]),
			.out_v     (v_c[i+1]),
			.out_num   (num_c[i+1]),
			.out_blank (blank_c[i+1]),
			.out_digits(digits_c[i+1])
		);
	end

	dssc_seq #(
		.MAX_DIGITS(MAX_DIGITS),
		.CHANNELS_PER_DIGIT(CHANNELS_PER_DIGIT),
		.FULL_LEVEL(FULL_LEVEL)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.word_v     (v_c[MAX_DIGITS]),
		.word_blank (blank_c[MAX_DIGITS]),
		.word_digits(digits_c[MAX_DIGITS]),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.channel    (channel),
		.level      (level),
		.latch      (latch),
		.last       (last)
	);

	`DSSC_ASSERT_IMP(a_last_latch, out_valid && last, latch, "last write without latch")
	`DSSC_ASSERT_NXT(a_accept_lands, in_valid && in_ready, v_c[1], "accepted word lost")
	`DSSC_ASSERT_IMP(a_idle_takes, !stat.busy, stat.take, "idle sequencer refuses word")

endmodule

@@ hw/rtl/dssc_cell.sv @@
// one digit cell: peels the low decimal digit off the number and passes the rest on
`timescale 1ns / 1ps
module dssc_cell #(
	parameter int MAX_DIGITS = 8,
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      in_v,
	input  logic [dssc_pkg::VALUE_W-1:0] in_num,
	input  logic                      in_blank,
	input  logic [4*MAX_DIGITS-1:0]   in_digits,
	output logic                      out_v,
	output logic [dssc_pkg::VALUE_W-1:0] out_num,
	output logic                      out_blank,
	output logic [4*MAX_DIGITS-1:0]   out_digits
);
	import dssc_pkg::*;

	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] quo;
	logic [VALUE_W-1:0] quo10;
	logic [3:0]         rem;
	logic [4*MAX_DIGITS-1:0] digits_d;
	logic               v_q;
	logic [VALUE_W-1:0] num_q;
	logic               blank_q;
	logic [4*MAX_DIGITS-1:0] digits_q;

	// divide by ten through the reciprocal
	always_comb begin
		prod  = PROD_W'(in_num) * PROD_W'(RECIP10);
		quo   = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);
		quo10 = VALUE_W'({quo, 3'b000}) + VALUE_W'({quo, 1'b0});
		rem   = 4'(in_num - quo10);
		digits_d = in_digits;
		digits_d[IDX*4 +: 4] = rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_q    <= quo;
			blank_q  <= in_blank;
			digits_q <= digits_d;
		end
	end

	assign out_v      = v_q;
	assign out_num    = num_q;
	assign out_blank  = blank_q;
	assign out_digits = digits_q;

endmodule

@@ hw/rtl/dssc_seq.sv @@
// write sequencer: walks digits and segments of one word and drives the output register
`timescale 1ns / 1ps
module dssc_seq #(
	parameter int MAX_DIGITS = 8,
	parameter int CHANNELS_PER_DIGIT = 8,
	parameter int FULL_LEVEL = 4095
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dssc_pkg::cfg_t                cfg,
	input  logic                          word_v,
	input  logic                          word_blank,
	input  logic [4*MAX_DIGITS-1:0]       word_digits,
	output dssc_pkg::seq_stat_t           stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dssc_pkg::CHAN_W-1:0]   channel,
	output logic [dssc_pkg::LEVEL_W-1:0]  level,
	output logic                          latch,
	output logic                          last
);
	import dssc_pkg::*;

	localparam int KW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	logic                    busy_q;
	logic [KW-1:0]           k_q;
	logic [2:0]              s_q;
	logic                    blank_q;
	logic [4*MAX_DIGITS-1:0] digits_q;
	logic                    out_v_q;
	logic [CHAN_W-1:0]       chan_q;
	logic [LEVEL_W-1:0]      level_q;
	logic                    latch_q;
	logic                    last_q;

	logic                    emit;
	logic                    seg_last;
	logic                    fin;
	logic                    take;
	logic                    load;
	logic [3:0]              digit;
	logic [NUM_SEGS-1:0]     pat;
	logic                    lit;
	logic [CNT_W-1:0]        pos;
	logic [CHAN_W-1:0]       pos_ch;
	logic [CHAN_W-1:0]       chan_d;
	logic [LEVEL_W-1:0]      on_lvl;
	logic [LEVEL_W-1:0]      off_lvl;

	always_comb begin
		emit     = busy_q && (!out_v_q || out_ready);
		seg_last = (s_q == SEG_LAST);
		fin      = seg_last && (CNT_W'(k_q) == cfg.n - 4'd1);
		take     = !busy_q || (emit && fin);
		load     = word_v && take;
		digit    = digits_q[k_q*4 +: 4];
		pat      = seg_pattern(digit);
		lit      = !blank_q && pat[s_q];
		pos      = cfg.n - 4'd1 - CNT_W'(k_q);
		pos_ch   = CHAN_W'(pos) * CHAN_W'(CHANNELS_PER_DIGIT);
		chan_d   = CHAN_W'(cfg.segment_map[s_q*3 +: 3]) + pos_ch;
		on_lvl   = cfg.common_anode ? LEVEL_W'(FULL_LEVEL) : '0;
		off_lvl  = cfg.common_anode ? '0 : LEVEL_W'(FULL_LEVEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			s_q    <= '0;
		end else if (load) begin
			busy_q <= (cfg.n != '0);
			k_q    <= '0;
			s_q    <= '0;
		end else if (emit) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else if (seg_last) begin
				s_q <= '0;
				k_q <= KW'(k_q + 1'b1);
			end else begin
				s_q <= 3'(s_q + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			blank_q  <= word_blank;
			digits_q <= word_digits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			chan_q  <= chan_d;
			level_q <= lit ? on_lvl : off_lvl;
			latch_q <= blank_q ? fin : seg_last;
			last_q  <= fin;
		end
	end

	assign stat.busy = busy_q;
	assign stat.take = take;
	assign out_valid = out_v_q;
	assign channel   = chan_q;
	assign level     = level_q;
	assign latch     = latch_q;
	assign last      = last_q;

endmodule
